### rtl/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is asserted
`define DDO_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ddo assertion failed");

// clocked assertion that also holds during reset
`define DDO_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("ddo assertion failed");

`endif

### rtl/ddo_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddo_pkg
// Types, constants and tables for the differential drive odometry block.
// ----------------------------------------------------------------------------
package ddo_pkg;

    // timestamp width
    localparam int TIME_BITS = 48;
    // width of the velocity dividend: (64-bit magnitude * 10^6) >> 16
    localparam int DIV_W = 68;
    // cordic iterations
    localparam int CORDIC_ITERS = 30;

    // configuration port
    localparam int CFG_ADDR_W = 3;
    localparam logic REG_DIST = 1'b0;
    localparam logic REG_TURN = 1'b1;
    localparam logic [31:0] DIST_RESET = 32'd2653356;
    localparam logic [31:0] TURN_RESET = 32'd54273092;

    // 2^64 / (2 pi) split into halves
    localparam logic [31:0] INV_2PI_LO = 32'h9391054A;
    localparam logic [31:0] INV_2PI_HI = 32'h28BE60DB;
    // cordic start vector and unit in Q1.30
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;
    // microseconds per second
    localparam logic [31:0] US_PER_S = 32'd1000000;
    // glitch limit on a count delta
    localparam logic signed [32:0] GLITCH_LIMIT = 33'sd1073741824;

    typedef struct packed {
        logic signed [31:0] left_count;
        logic signed [31:0] right_count;
        logic [TIME_BITS-1:0] time_us;
    } t_in_item;

    typedef struct packed {
        logic signed [63:0] pos_x;
        logic signed [63:0] pos_y;
        logic [31:0] heading;
        logic signed [31:0] quat_z;
        logic signed [31:0] quat_w;
        logic signed [31:0] lin_vel;
        logic signed [31:0] ang_vel;
        logic dt_zero;
    } t_out_item;

    // arctangent of 2^-i as a binary angle
    function automatic logic [31:0] atan_bam(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0: v = 32'h20000000;
            5'd1: v = 32'h12E4051E;
            5'd2: v = 32'h09FB385B;
            5'd3: v = 32'h051111D4;
            5'd4: v = 32'h028B0D43;
            5'd5: v = 32'h0145D7E1;
            5'd6: v = 32'h00A2F61E;
            5'd7: v = 32'h00517C55;
            5'd8: v = 32'h0028BE53;
            5'd9: v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000029;
            5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;
            5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000003;
            5'd29: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

### rtl/ddo_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddo_cordic
// Iterative rotation-mode cordic: cosine and sine of a binary angle in Q1.30.
// ----------------------------------------------------------------------------
module ddo_cordic (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [31:0]        i_angle,
    output logic               o_done,
    output logic signed [31:0] o_cos,
    output logic signed [31:0] o_sin
);

    logic               r_busy, n_busy;
    logic               r_done, n_done;
    logic [4:0]         r_i, n_i;
    logic               r_flip, n_flip;
    logic signed [33:0] r_x, n_x;
    logic signed [33:0] r_y, n_y;
    logic signed [33:0] r_z, n_z;

    logic signed [33:0] ang_s, rot_s, dx, dy, at, fx, fy;
    logic [31:0]        rot;

    // fold, iterate, finish
    always_comb begin
        ang_s = {{2{i_angle[31]}}, i_angle};
        rot = i_angle + 32'h80000000;
        rot_s = {{2{rot[31]}}, rot};
        dx = r_y >>> r_i;
        dy = r_x >>> r_i;
        at = $signed({2'b00, ddo_pkg::atan_bam(r_i)});
        n_busy = r_busy;
        n_done = 1'b0;
        n_i = r_i;
        n_flip = r_flip;
        n_x = r_x;
        n_y = r_y;
        n_z = r_z;
        if (i_start) begin
            n_busy = 1'b1;
            n_i = 5'd0;
            n_x = ddo_pkg::CORDIC_GAIN;
            n_y = 34'sd0;
            if (ang_s > ddo_pkg::ONE_Q30 || ang_s < -ddo_pkg::ONE_Q30) begin
                n_z = rot_s;
                n_flip = 1'b1;
            end else begin
                n_z = ang_s;
                n_flip = 1'b0;
            end
        end else if (r_busy) begin
            if (!r_z[33]) begin
                n_x = r_x - dx;
                n_y = r_y + dy;
                n_z = r_z - at;
            end else begin
                n_x = r_x + dx;
                n_y = r_y - dy;
                n_z = r_z + at;
            end
            n_i = r_i + 5'd1;
            if (r_i == 5'(ddo_pkg::CORDIC_ITERS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // sign fix and clamp to one
    always_comb begin
        fx = r_flip ? -r_x : r_x;
        fy = r_flip ? -r_y : r_y;
        if (fx > ddo_pkg::ONE_Q30) fx = ddo_pkg::ONE_Q30;
        else if (fx < -ddo_pkg::ONE_Q30) fx = -ddo_pkg::ONE_Q30;
        if (fy > ddo_pkg::ONE_Q30) fy = ddo_pkg::ONE_Q30;
        else if (fy < -ddo_pkg::ONE_Q30) fy = -ddo_pkg::ONE_Q30;
        o_cos = fx[31:0];
        o_sin = fy[31:0];
    end

    assign o_done = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i <= 5'd0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_i <= n_i;
        end
        r_flip <= n_flip;
        r_x <= n_x;
        r_y <= n_y;
        r_z <= n_z;
    end

endmodule

### rtl/ddo_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddo_div
// Bit-serial restoring divider for the velocities, quotient capped to 32 bits.
// ----------------------------------------------------------------------------
module ddo_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [ddo_pkg::DIV_W-1:0]     i_num,
    input  logic [ddo_pkg::TIME_BITS-1:0] i_den,
    input  logic                          i_neg,
    output logic                          o_done,
    output logic [31:0]                   o_quot
);

    localparam int DW = ddo_pkg::DIV_W;
    localparam int TB = ddo_pkg::TIME_BITS;
    localparam int CW = $clog2(DW);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_neg, n_neg;
    logic [DW-1:0] r_num, n_num;
    logic [DW-1:0] r_quo, n_quo;
    logic [TB:0]   r_rem, n_rem;
    logic [TB-1:0] r_den, n_den;

    logic [TB:0]   rem_sh;
    logic          ge;
    logic [31:0]   cap, qv;
    logic          over;

    // one quotient bit per cycle
    always_comb begin
        rem_sh = {r_rem[TB-1:0], r_num[DW-1]};
        ge = rem_sh >= {1'b0, r_den};
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt = r_cnt;
        n_neg = r_neg;
        n_num = r_num;
        n_quo = r_quo;
        n_rem = r_rem;
        n_den = r_den;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt = '0;
            n_neg = i_neg;
            n_num = i_num;
            n_quo = '0;
            n_rem = '0;
            n_den = i_den;
        end else if (r_busy) begin
            n_rem = ge ? (rem_sh - {1'b0, r_den}) : rem_sh;
            n_quo = {r_quo[DW-2:0], ge};
            n_num = {r_num[DW-2:0], 1'b0};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CW'(DW - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // saturate and apply sign
    always_comb begin
        cap = r_neg ? 32'h80000000 : 32'h7FFFFFFF;
        over = (|r_quo[DW-1:32]) || (r_quo[31:0] > cap);
        qv = over ? cap : r_quo[31:0];
        o_quot = r_neg ? (32'd0 - qv) : qv;
    end

    assign o_done = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt <= n_cnt;
        end
        r_neg <= n_neg;
        r_num <= n_num;
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_den <= n_den;
    end

endmodule

### rtl/differential_drive_odometry.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// differential_drive_odometry
// Wheel odometry: pose, yaw quaternion and velocities from encoder counts.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (i_in_valid / o_in_stall) takes absolute left and right
//   counts and a microsecond timestamp. The first transaction after reset only
//   primes the stored counts and time and produces no result.
//   Each later transaction produces one result on the output channel
//   (o_out_valid / i_out_stall): position, heading, quaternion, velocities.
//   One shared 32x32 multiplier, one iterative cordic and one bit-serial
//   divider do the work under a sequencer; o_in_stall is high while busy.
//   Per transaction: two cordic runs, two divisions, 14 multiplier partials
//   and a load of the output register; the divisions are skipped when the
//   elapsed time is zero. A finished result sits in an output register; the
//   next input is taken while it waits, and a new result waits in the
//   sequencer until the output register is free, so a stalled receiver
//   holds the block after two results. Reset clears the pose, the primed
//   flag and loads the default scales. The user must write the scale
//   registers over the APB port only while idle; the block itself does
//   not enforce it.
// ----------------------------------------------------------------------------
module differential_drive_odometry (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  ddo_pkg::t_in_item               i_in_data,
    output logic                            o_in_stall,
    output logic                            o_out_valid,
    output ddo_pkg::t_out_item              o_out_data,
    input  logic                            i_out_stall,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ddo_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    localparam int TB = ddo_pkg::TIME_BITS;
    localparam int DW = ddo_pkg::DIV_W;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_MC    = 4'd1;
    localparam logic [3:0] ST_MP    = 4'd2;
    localparam logic [3:0] ST_STEP  = 4'd3;
    localparam logic [3:0] ST_COR_H = 4'd4;
    localparam logic [3:0] ST_XS    = 4'd5;
    localparam logic [3:0] ST_YS    = 4'd6;
    localparam logic [3:0] ST_COR_Q = 4'd7;
    localparam logic [3:0] ST_VL    = 4'd8;
    localparam logic [3:0] ST_DIV_L = 4'd9;
    localparam logic [3:0] ST_VA    = 4'd10;
    localparam logic [3:0] ST_DIV_A = 4'd11;
    localparam logic [3:0] ST_DONE  = 4'd12;

    logic [3:0]          r_state, n_state;
    logic [2:0]          r_cnt, n_cnt;
    logic [127:0]        r_acc, n_acc;
    logic [63:0]         r_prod;
    logic                r_primed, n_primed;
    logic [31:0]         r_prev_l, n_prev_l, r_prev_r, n_prev_r;
    logic [TB-1:0]       r_last_t, n_last_t, r_dt, n_dt;
    logic [31:0]         r_msum, n_msum, r_mdiff, n_mdiff;
    logic                r_nc, n_nc, r_np, n_np;
    logic [63:0]         r_mc, n_mc, r_mp, n_mp;
    logic signed [63:0]  r_x, n_x, r_y, n_y;
    logic [31:0]         r_angle, n_angle;
    logic signed [31:0]  r_cos, n_cos, r_sin, n_sin;
    logic signed [31:0]  r_qz, n_qz, r_qw, n_qw;
    logic [31:0]         r_lin, n_lin, r_angv, n_angv;
    logic                r_cor_start, n_cor_start;
    logic [31:0]         r_cor_ang, n_cor_ang;
    logic                r_div_start, n_div_start;
    logic [DW-1:0]       r_div_num, n_div_num;
    logic                r_div_neg, n_div_neg;
    logic                r_out_valid, n_out_valid;
    ddo_pkg::t_out_item  r_out, n_out;
    logic [31:0]         r_dist, n_dist, r_turn, n_turn;

    logic                cor_done, div_done;
    logic signed [31:0]  cor_cos, cor_sin;
    logic [31:0]         div_quot;

    logic [31:0]         mul_a, mul_b;
    logic [1:0]          mul_sh, last_idx;
    logic [127:0]        acc_sum;
    logic                accept, cfg_wr;
    logic signed [32:0]  dl, dr, dlg, drg, sum, diff;
    logic [31:0]         step, new_ang;
    logic signed [31:0]  fsel;
    logic [31:0]         fabs;
    logic                tneg;
    logic [63:0]         tmag;
    logic signed [63:0]  term, pos_sel;
    logic signed [64:0]  pos_sum;
    logic signed [63:0]  pos_sat;

    ddo_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_cor_start),
        .i_angle (r_cor_ang),
        .o_done  (cor_done),
        .o_cos   (cor_cos),
        .o_sin   (cor_sin)
    );

    ddo_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (r_div_num),
        .i_den   (r_dt),
        .i_neg   (r_div_neg),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // handshakes
    assign o_in_stall = (r_state != ST_IDLE);
    assign accept = i_in_valid && (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data = r_out;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == ddo_pkg::REG_TURN) ? r_turn : r_dist;

    // delta and glitch filter
    always_comb begin
        dl = $signed({i_in_data.left_count[31], i_in_data.left_count})
           - $signed({r_prev_l[31], r_prev_l});
        dr = $signed({i_in_data.right_count[31], i_in_data.right_count})
           - $signed({r_prev_r[31], r_prev_r});
        dlg = (dl > ddo_pkg::GLITCH_LIMIT || dl < -ddo_pkg::GLITCH_LIMIT) ? 33'sd0 : dl;
        drg = (dr > ddo_pkg::GLITCH_LIMIT || dr < -ddo_pkg::GLITCH_LIMIT) ? 33'sd0 : dr;
        sum = dlg + drg;
        diff = drg - dlg;
    end

    // shared multiplier operand select
    always_comb begin
        mul_a = r_msum;
        mul_b = r_dist;
        mul_sh = 2'd0;
        last_idx = 2'd0;
        fsel = (r_state == ST_YS) ? r_sin : r_cos;
        fabs = fsel[31] ? (32'd0 - fsel) : fsel;
        case (r_state)
            ST_MP: begin
                mul_a = r_mdiff;
                mul_b = r_turn;
            end
            ST_STEP: begin
                last_idx = 2'd3;
                mul_a = r_cnt[2] ? r_mp[63:32] : r_mp[31:0];
                mul_b = r_cnt[1] ? ddo_pkg::INV_2PI_HI : ddo_pkg::INV_2PI_LO;
                mul_sh = 2'(r_cnt[2]) + 2'(r_cnt[1]);
            end
            ST_XS, ST_YS: begin
                last_idx = 2'd1;
                mul_a = r_cnt[1] ? r_mc[63:32] : r_mc[31:0];
                mul_b = fabs;
                mul_sh = {1'b0, r_cnt[1]};
            end
            ST_VL: begin
                last_idx = 2'd1;
                mul_a = r_cnt[1] ? r_mc[63:32] : r_mc[31:0];
                mul_b = ddo_pkg::US_PER_S;
                mul_sh = {1'b0, r_cnt[1]};
            end
            ST_VA: begin
                last_idx = 2'd1;
                mul_a = r_cnt[1] ? r_mp[63:32] : r_mp[31:0];
                mul_b = ddo_pkg::US_PER_S;
                mul_sh = {1'b0, r_cnt[1]};
            end
            default: begin
                mul_a = r_msum;
                mul_b = r_dist;
            end
        endcase
    end

    // accumulate the registered partial product
    always_comb begin
        case (mul_sh)
            2'd0: acc_sum = r_acc + {64'd0, r_prod};
            2'd1: acc_sum = r_acc + {32'd0, r_prod, 32'd0};
            2'd2: acc_sum = r_acc + {r_prod, 64'd0};
            default: acc_sum = r_acc;
        endcase
    end

    // heading step, position term and saturating add
    always_comb begin
        step = acc_sum[95:64];
        new_ang = r_np ? (r_angle - step) : (r_angle + step);
        tneg = r_nc ^ fsel[31];
        tmag = acc_sum[93:30];
        term = tneg ? -$signed(tmag) : $signed(tmag);
        pos_sel = (r_state == ST_YS) ? r_y : r_x;
        pos_sum = {pos_sel[63], pos_sel} + {term[63], term};
        if (pos_sum[64] != pos_sum[63])
            pos_sat = pos_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        else
            pos_sat = pos_sum[63:0];
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_cnt = r_cnt;
        n_acc = r_acc;
        n_primed = r_primed;
        n_prev_l = r_prev_l;
        n_prev_r = r_prev_r;
        n_last_t = r_last_t;
        n_dt = r_dt;
        n_msum = r_msum;
        n_mdiff = r_mdiff;
        n_nc = r_nc;
        n_np = r_np;
        n_mc = r_mc;
        n_mp = r_mp;
        n_x = r_x;
        n_y = r_y;
        n_angle = r_angle;
        n_cos = r_cos;
        n_sin = r_sin;
        n_qz = r_qz;
        n_qw = r_qw;
        n_lin = r_lin;
        n_angv = r_angv;
        n_cor_start = 1'b0;
        n_cor_ang = r_cor_ang;
        n_div_start = 1'b0;
        n_div_num = r_div_num;
        n_div_neg = r_div_neg;
        n_out_valid = r_out_valid && i_out_stall;
        n_out = r_out;
        n_dist = r_dist;
        n_turn = r_turn;

        // scale register writes
        if (cfg_wr) begin
            if (paddr[2] == ddo_pkg::REG_TURN) n_turn = pwdata;
            else n_dist = pwdata;
        end

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_prev_l = i_in_data.left_count;
                    n_prev_r = i_in_data.right_count;
                    n_last_t = i_in_data.time_us;
                    n_primed = 1'b1;
                    if (r_primed) begin
                        n_dt = i_in_data.time_us - r_last_t;
                        n_nc = sum[32];
                        n_np = diff[32];
                        n_msum = sum[32] ? 32'(-sum) : sum[31:0];
                        n_mdiff = diff[32] ? 32'(-diff) : diff[31:0];
                        n_acc = '0;
                        n_cnt = '0;
                        n_state = ST_MC;
                    end
                end
            end
            ST_MC, ST_MP, ST_STEP, ST_XS, ST_YS, ST_VL, ST_VA: begin
                if (!r_cnt[0]) begin
                    n_cnt = r_cnt + 3'd1;
                end else if (r_cnt[2:1] != last_idx) begin
                    n_acc = acc_sum;
                    n_cnt = r_cnt + 3'd1;
                end else begin
                    n_acc = '0;
                    n_cnt = '0;
                    case (r_state)
                        ST_MC: begin
                            n_mc = {1'b0, acc_sum[63:1]};
                            n_state = ST_MP;
                        end
                        ST_MP: begin
                            n_mp = acc_sum[63:0];
                            n_state = ST_STEP;
                        end
                        ST_STEP: begin
                            n_angle = new_ang;
                            n_cor_ang = new_ang;
                            n_cor_start = 1'b1;
                            n_state = ST_COR_H;
                        end
                        ST_XS: begin
                            n_x = pos_sat;
                            n_state = ST_YS;
                        end
                        ST_YS: begin
                            n_y = pos_sat;
                            n_cor_ang = {1'b0, r_angle[31:1]};
                            n_cor_start = 1'b1;
                            n_state = ST_COR_Q;
                        end
                        ST_VL: begin
                            n_div_num = acc_sum[DW+15:16];
                            n_div_neg = r_nc;
                            n_div_start = 1'b1;
                            n_state = ST_DIV_L;
                        end
                        default: begin
                            n_div_num = acc_sum[DW+15:16];
                            n_div_neg = r_np;
                            n_div_start = 1'b1;
                            n_state = ST_DIV_A;
                        end
                    endcase
                end
            end
            ST_COR_H: begin
                if (cor_done) begin
                    n_cos = cor_cos;
                    n_sin = cor_sin;
                    n_state = ST_XS;
                end
            end
            ST_COR_Q: begin
                if (cor_done) begin
                    n_qz = cor_sin;
                    n_qw = cor_cos;
                    if (r_dt == '0) begin
                        n_lin = '0;
                        n_angv = '0;
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_VL;
                    end
                end
            end
            ST_DIV_L: begin
                if (div_done) begin
                    n_lin = div_quot;
                    n_state = ST_VA;
                end
            end
            ST_DIV_A: begin
                if (div_done) begin
                    n_angv = div_quot;
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                // load the output register once it is free
                if (!r_out_valid || !i_out_stall) begin
                    n_out.pos_x = r_x;
                    n_out.pos_y = r_y;
                    n_out.heading = r_angle;
                    n_out.quat_z = r_qz;
                    n_out.quat_w = r_qw;
                    n_out.lin_vel = r_lin;
                    n_out.ang_vel = r_angv;
                    n_out.dt_zero = (r_dt == '0);
                    n_out_valid = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt <= '0;
            r_primed <= 1'b0;
            r_prev_l <= '0;
            r_prev_r <= '0;
            r_last_t <= '0;
            r_x <= '0;
            r_y <= '0;
            r_angle <= '0;
            r_cor_start <= 1'b0;
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
            r_dist <= ddo_pkg::DIST_RESET;
            r_turn <= ddo_pkg::TURN_RESET;
        end else begin
            r_state <= n_state;
            r_cnt <= n_cnt;
            r_primed <= n_primed;
            r_prev_l <= n_prev_l;
            r_prev_r <= n_prev_r;
            r_last_t <= n_last_t;
            r_x <= n_x;
            r_y <= n_y;
            r_angle <= n_angle;
            r_cor_start <= n_cor_start;
            r_div_start <= n_div_start;
            r_out_valid <= n_out_valid;
            r_dist <= n_dist;
            r_turn <= n_turn;
        end
        r_acc <= n_acc;
        r_prod <= {32'd0, mul_a} * {32'd0, mul_b};
        r_dt <= n_dt;
        r_msum <= n_msum;
        r_mdiff <= n_mdiff;
        r_nc <= n_nc;
        r_np <= n_np;
        r_mc <= n_mc;
        r_mp <= n_mp;
        r_cos <= n_cos;
        r_sin <= n_sin;
        r_qz <= n_qz;
        r_qw <= n_qw;
        r_lin <= n_lin;
        r_angv <= n_angv;
        r_cor_ang <= n_cor_ang;
        r_div_num <= n_div_num;
        r_div_neg <= n_div_neg;
        r_out <= n_out;
    end

endmodule

### rtl/ddo_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddo_checker
// Port-level checks for the differential drive odometry block.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ddo_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input ddo_pkg::t_in_item              i_in_data,
    input logic                           o_in_stall,
    input logic                           o_out_valid,
    input ddo_pkg::t_out_item             o_out_data,
    input logic                           i_out_stall,
    input logic                           psel,
    input logic                           penable,
    input logic                           pwrite,
    input logic [ddo_pkg::CFG_ADDR_W-1:0] paddr,
    input logic [31:0]                    pwdata,
    input logic [31:0]                    prdata,
    input logic                           pready
);

    // a stalled result transaction holds
    `DDO_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))

    // the block is ready right after reset
    `DDO_ASSERT(a_ready_after_rst, i_clk, i_rst_n, !$past(i_rst_n) |-> !o_in_stall)

    // zero elapsed time forces zero velocities
    `DDO_ASSERT(a_dt_zero_vel, i_clk, i_rst_n, o_out_valid && o_out_data.dt_zero |-> o_out_data.lin_vel == 32'sd0 && o_out_data.ang_vel == 32'sd0)

    // quaternion components stay within one
    `DDO_ASSERT(a_quat_range, i_clk, i_rst_n, o_out_valid |-> o_out_data.quat_z <= 32'sd1073741824 && o_out_data.quat_z >= -32'sd1073741824 && o_out_data.quat_w <= 32'sd1073741824 && o_out_data.quat_w >= -32'sd1073741824)

endmodule

bind differential_drive_odometry ddo_checker u_ddo_checker (.*);
